>>> src/assert_macros.svh
// Assertion macros for the RTL of the ordered sequence store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define OSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define OSQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSQ_ASSERT(label, prop, msg)
`define OSQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> src/osq_pkg.sv
// Types and command codes shared by the ordered sequence store modules.
package osq_pkg;

  // Command codes carried on the op field.
  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE         = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_t;

  // Per-cycle control broadcast to every storage cell.
  typedef struct packed {
    logic shift;  // every cell that wr does not hit takes its right neighbor's value
    logic wr;     // the cell at the tail index takes the broadcast value
  } cell_ctl_t;

endpackage

>>> src/ordered_sequence_store.sv
// Top level of the ordered sequence store: a chain of item cells run as a rotating queue.
//
// The store holds up to CAPACITY items of ITEM_BITS bits in a row of cells.
// Every command walks the held items once past the head cell: each cycle the
// head item is popped, looked at, and pushed back at the tail (or dropped, or
// replaced), while the other cells shift one place toward the head. An insert
// adds a step in which the new item is pushed at the tail without a pop.
// After the walk the items sit again at cell 0 onward, in list order. A
// command's result is presented once its walk is done; a command that is
// rejected for a bad position or a full store walks no items. The single
// head read sets the pace of the walk. The next command is accepted in the
// cycle after the result is loaded. A new command is accepted once the
// previous walk is finished, even while its result still waits in the output
// register; a finished walk waits for that register to be free. Commands
// whose position is out of range, and inserts into a full store, return ok=0
// and leave the contents alone. Op code 7 returns ok=0 with only occupancy
// set. Items wider than the 32-bit ports are zero-extended on entry and
// truncated on read; index, removed and occupancy report the low five bits
// of counts.
`include "assert_macros.svh"

module ordered_sequence_store #(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  op,
  input  logic [4:0]  pos,
  input  logic [31:0] item,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [4:0]  index,
  output logic [31:0] data_out,
  output logic [4:0]  removed,
  output logic [4:0]  occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                state;
  osq_pkg::op_t          op_r;
  logic [CW-1:0]         pos_r;
  logic [ITEM_BITS-1:0]  item_r;
  logic [CW-1:0]         count;   // items held in the chain right now
  logic [CW-1:0]         n;       // items to walk in this command
  logic [CW-1:0]         k;       // items walked so far
  logic                  pend;    // an insert still has to place its item
  logic                  ok_r;
  logic [CW-1:0]         idx_r;
  logic [ITEM_BITS-1:0]  data_r;
  logic [CW-1:0]         rem_r;

  logic [ITEM_BITS-1:0]  cell_q [CAPACITY];
  logic [ITEM_BITS-1:0]  head;
  osq_pkg::cell_ctl_t    ctl;
  logic [CW-1:0]         tail;
  logic [ITEM_BITS-1:0]  push_val;

  osq_pkg::op_t          cmd_op;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         fill_w;
  logic                  act;
  logic                  run;
  logic                  at_pos;
  logic                  walk_done;
  logic                  push_only;
  logic                  pop;
  logic                  hit_eq;
  logic                  drop;
  logic                  finish;
  logic                  rsp_free;
  logic                  cmd_fire;

  assign head = cell_q[0];

  // ---------------------------------------------------------------------
  // Chain of cells. Each cell looks only at its right neighbor.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] right;
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    osq_cell #(
      .IDX       (i),
      .CW        (CW),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .tail  (tail),
      .din   (push_val),
      .right (right),
      .q     (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Command check at acceptance.
  // ---------------------------------------------------------------------
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cmd_op    = osq_pkg::op_t'(op);
  assign pos_w     = PW'(pos);
  assign fill_w    = PW'(count);

  always_comb begin
    case (cmd_op)
      osq_pkg::OP_INSERT_AT:     act = (pos_w <= fill_w) && (count < CW'(CAPACITY));
      osq_pkg::OP_INSERT_SORTED: act = (count < CW'(CAPACITY));
      osq_pkg::OP_ERASE,
      osq_pkg::OP_GET,
      osq_pkg::OP_SET:           act = (pos_w < fill_w);
      osq_pkg::OP_REMOVE_ALL,
      osq_pkg::OP_FIND:          act = 1'b1;
      default:                   act = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // One walk step per cycle while running.
  // ---------------------------------------------------------------------
  assign run       = (state == ST_RUN);
  assign at_pos    = (k == pos_r);
  assign walk_done = (k == n);
  assign hit_eq    = (head == item_r);

  // The new item goes in ahead of the head item, or at the end of the walk.
  assign push_only = pend &&
                     (((op_r == osq_pkg::OP_INSERT_AT) && at_pos) ||
                      ((op_r == osq_pkg::OP_INSERT_SORTED) &&
                       (walk_done || (item_r <= head))));
  assign pop       = !push_only && !walk_done;
  assign drop      = ((op_r == osq_pkg::OP_ERASE) && at_pos) ||
                     ((op_r == osq_pkg::OP_REMOVE_ALL) && hit_eq);
  assign finish    = run && !pend && walk_done;
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    ctl.shift = run && pop;
    ctl.wr    = run && (push_only || (pop && !drop));
    // A pop moves the tail down one place before the push lands.
    tail      = push_only ? count : count - CW'(1);
    if (push_only || ((op_r == osq_pkg::OP_SET) && at_pos)) begin
      push_val = item_r;
    end else begin
      push_val = head;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            state  <= ST_RUN;
            op_r   <= cmd_op;
            pos_r  <= CW'(pos);
            item_r <= ITEM_BITS'(item);
            n      <= count;
            k      <= act ? '0 : count;
            pend   <= act && ((cmd_op == osq_pkg::OP_INSERT_AT) ||
                              (cmd_op == osq_pkg::OP_INSERT_SORTED));
            ok_r   <= act && (cmd_op != osq_pkg::OP_FIND);
            idx_r  <= '0;
            data_r <= '0;
            rem_r  <= '0;
          end
        end
        ST_RUN: begin
          if (push_only) begin
            pend  <= 1'b0;
            count <= count + CW'(1);
            if (op_r == osq_pkg::OP_INSERT_SORTED) begin
              idx_r <= k;
            end
          end else if (pop) begin
            k <= k + CW'(1);
            if (drop) begin
              count <= count - CW'(1);
            end
            if ((op_r == osq_pkg::OP_REMOVE_ALL) && hit_eq) begin
              rem_r <= rem_r + CW'(1);
            end
            if ((op_r == osq_pkg::OP_GET) && at_pos) begin
              data_r <= head;
            end
            if ((op_r == osq_pkg::OP_FIND) && !ok_r && hit_eq) begin
              ok_r  <= 1'b1;
              idx_r <= k;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (finish && rsp_free) begin
        state     <= ST_IDLE;
        rsp_valid <= 1'b1;
        ok        <= ok_r;
        index     <= 5'(idx_r);
        data_out  <= 32'(data_r);
        removed   <= 5'(rem_r);
        occupancy <= 5'(count);
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `OSQ_ASSERT(a_count_bound, count <= CW'(CAPACITY), "occupancy exceeds capacity")
  `OSQ_ASSERT(a_walk_bound, (state == ST_RUN) |-> (k <= n), "walk ran past its item count")
  `OSQ_ASSERT(a_push_room, (state == ST_RUN) && pend |-> (count < CW'(CAPACITY)), "insert into full chain")
  `OSQ_ASSERT(a_insert_grows, $rose(rsp_valid) && ok && ((op_r == osq_pkg::OP_INSERT_AT) || (op_r == osq_pkg::OP_INSERT_SORTED)) |-> (count == n + CW'(1)), "insert did not add one item")
  `OSQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE) && !rsp_valid, "reset left work pending")

endmodule

>>> src/osq_cell.sv
// One storage cell of the chain: holds one item and hands it to its left neighbor.
module osq_cell #(
  parameter int IDX       = 0,
  parameter int CW        = 5,
  parameter int ITEM_BITS = 32
) (
  input  logic                  clk,
  input  osq_pkg::cell_ctl_t    ctl,
  input  logic [CW-1:0]         tail,
  input  logic [ITEM_BITS-1:0]  din,
  input  logic [ITEM_BITS-1:0]  right,
  output logic [ITEM_BITS-1:0]  q
);

  logic hit;

  assign hit = ctl.wr && (tail == CW'(IDX));

  always_ff @(posedge clk) begin
    if (hit) begin
      q <= din;
    end else if (ctl.shift) begin
      q <= right;
    end
  end

endmodule
